@@ src/assert_macros.svh @@
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is held.
`define RMQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also runs through reset.
`define RMQ_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define RMQ_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

@@ src/rmq_pkg.sv @@
package rmq_pkg;
  localparam int FRAC_BITS = 14;
  localparam int DATA_W    = 16;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int LIM       = (ONE > 32767) ? 32767 : ONE;
  localparam int ROOT_W    = 16;
  localparam int SQ_W      = 2 * ROOT_W;
  localparam int Q_W       = 15;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int LANES     = 3;

  // Side data that travels with a word through the root and divide stages.
  typedef struct packed {
    logic                               degen;
    logic [LANES-1:0]                   neg;
    logic [LANES-1:0][DATA_W-1:0]       mag;
  } carry_t;

  // One stage of the divider pipeline.
  typedef struct packed {
    logic [DATA_W-1:0]                  qw;
    logic [DEN_W-1:0]                   den;
    logic [LANES-1:0][SQ_W-1:0]         rem;
    logic [LANES-1:0][Q_W-1:0]          q;
    logic [LANES-1:0]                   ovf;
    carry_t                             car;
  } div_stage_t;
endpackage

@@ src/rmq_sqrt.sv @@
module rmq_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rmq_pkg::SQ_W-1:0]    in_n,
  input  rmq_pkg::carry_t             in_car,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rmq_pkg::ROOT_W-1:0]  out_root,
  output rmq_pkg::carry_t             out_car
);
  import rmq_pkg::*;

  logic [SQ_W-1:0] n_r   [ROOT_W];
  logic [SQ_W-1:0] res_r [ROOT_W];
  carry_t          car_r [ROOT_W];
  logic [ROOT_W-1:0] v_r;
  logic [ROOT_W:0]   rdy;

  assign rdy[ROOT_W] = out_ready;
  assign in_ready    = rdy[0];

  // One result bit per stage, highest bit first.
  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam logic [SQ_W-1:0] SBIT = SQ_W'(1) << (SQ_W - 2 - 2 * s);
    logic [SQ_W-1:0] n_in, res_in, sum, n_nxt, res_nxt;
    logic            v_in;
    carry_t          car_in;

    if (s == 0) begin : g_first
      assign n_in   = in_n;
      assign res_in = '0;
      assign v_in   = in_valid;
      assign car_in = in_car;
    end else begin : g_next
      assign n_in   = n_r[s-1];
      assign res_in = res_r[s-1];
      assign v_in   = v_r[s-1];
      assign car_in = car_r[s-1];
    end

    assign rdy[s] = !v_r[s] || rdy[s+1];

    always_comb begin
      sum = res_in + SBIT;
      if (n_in >= sum) begin
        n_nxt   = n_in - sum;
        res_nxt = (res_in >> 1) + SBIT;
      end else begin
        n_nxt   = n_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= v_in;
      end
      if (rdy[s] && v_in) begin
        n_r[s]   <= n_nxt;
        res_r[s] <= res_nxt;
        car_r[s] <= car_in;
      end
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign out_root  = res_r[ROOT_W-1][ROOT_W-1:0];
  assign out_car   = car_r[ROOT_W-1];
endmodule

@@ src/rmq_div.sv @@
module rmq_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rmq_pkg::ROOT_W-1:0]  in_root,
  input  rmq_pkg::carry_t             in_car,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rmq_pkg::div_stage_t         out_st
);
  import rmq_pkg::*;

  localparam int NST = Q_W + 1;

  div_stage_t      st_r [NST];
  logic [NST-1:0]  v_r;
  logic [NST:0]    rdy;

  assign rdy[NST]  = out_ready;
  assign in_ready  = rdy[0];

  // Stage 0 forms the divisor, the clamped scalar part and the overflow test; each later stage
  // settles one quotient bit in all three lanes.
  for (genvar s = 0; s < NST; s++) begin : g_stage
    div_stage_t st_nxt;
    logic       v_in;

    assign rdy[s] = !v_r[s] || rdy[s+1];

    if (s == 0) begin : g_first
      logic [DEN_W-1:0] den;
      logic [SQ_W-1:0]  dtop;
      assign v_in = in_valid;
      assign den  = {in_root, 1'b0};
      assign dtop = SQ_W'(den) << Q_W;
      always_comb begin
        st_nxt     = '0;
        st_nxt.den = den;
        st_nxt.car = in_car;
        if (ROOT_W'(in_root >> 1) > ROOT_W'(LIM)) begin
          st_nxt.qw = DATA_W'(LIM);
        end else begin
          st_nxt.qw = DATA_W'(in_root >> 1);
        end
        for (int j = 0; j < LANES; j++) begin
          st_nxt.rem[j] = SQ_W'(in_car.mag[j]) << FRAC_BITS;
          st_nxt.ovf[j] = st_nxt.rem[j] >= dtop;
        end
      end
    end else begin : g_next
      localparam int K = Q_W - s;
      logic [SQ_W-1:0] dsh;
      assign v_in = v_r[s-1];
      assign dsh  = SQ_W'(st_r[s-1].den) << K;
      always_comb begin
        st_nxt = st_r[s-1];
        for (int j = 0; j < LANES; j++) begin
          if (st_r[s-1].rem[j] >= dsh) begin
            st_nxt.rem[j]  = st_r[s-1].rem[j] - dsh;
            st_nxt.q[j][K] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= v_in;
      end
      if (rdy[s] && v_in) begin
        st_r[s] <= st_nxt;
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_st    = st_r[NST-1];
endmodule

@@ src/rotation_matrix_to_quaternion.sv @@
// Pipeline: 1 setup stage, 16 square root stages, 16 divider stages, 1 output
// register.
// Throughput: one word per cycle; each stage holds one word and a stall
// holds only the stages that are full behind it.
// Reset: synchronous active-low rst_n clears all valid bits; data is not reset.
`include "assert_macros.svh"
module rotation_matrix_to_quaternion (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [15:0] in_r00,
  input  logic signed [15:0] in_r01,
  input  logic signed [15:0] in_r02,
  input  logic signed [15:0] in_r10,
  input  logic signed [15:0] in_r11,
  input  logic signed [15:0] in_r12,
  input  logic signed [15:0] in_r20,
  input  logic signed [15:0] in_r21,
  input  logic signed [15:0] in_r22,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_qw,
  output logic signed [15:0] out_qx,
  output logic signed [15:0] out_qy,
  output logic signed [15:0] out_qz,
  output logic        out_degenerate,
  output logic        out_saturated
);
  import rmq_pkg::*;

  // Setup stage: trace plus one and the three antisymmetric differences.
  logic               a_v_r;
  logic [SQ_W-1:0]    a_n_r;
  carry_t             a_car_r;
  logic               a_rdy, sq_in_ready;
  logic signed [17:0] t;
  logic signed [16:0] d [LANES];
  carry_t             car_nxt;
  logic [SQ_W-1:0]    n_nxt;

  assign t    = 18'(in_r00) + 18'(in_r11) + 18'(in_r22) + 18'(ONE);
  assign d[0] = 17'(in_r21) - 17'(in_r12);
  assign d[1] = 17'(in_r02) - 17'(in_r20);
  assign d[2] = 17'(in_r10) - 17'(in_r01);

  always_comb begin
    car_nxt.degen = (t <= 18'sd0);
    for (int j = 0; j < LANES; j++) begin
      car_nxt.neg[j] = d[j][16];
      car_nxt.mag[j] = d[j][16] ? DATA_W'(-d[j]) : DATA_W'(d[j]);
    end
    n_nxt = car_nxt.degen ? '0 : (SQ_W'(t[16:0]) << FRAC_BITS);
  end

  assign a_rdy    = !a_v_r || sq_in_ready;
  assign in_ready = a_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_rdy) begin
      a_v_r <= in_valid;
    end
    if (a_rdy && in_valid) begin
      a_n_r   <= n_nxt;
      a_car_r <= car_nxt;
    end
  end

  // Square root of (trace plus one) scaled to the fixed-point format.
  logic              sq_v, dv_in_ready;
  logic [ROOT_W-1:0] sq_root;
  carry_t            sq_car;

  rmq_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_v_r),
    .in_ready  (sq_in_ready),
    .in_n      (a_n_r),
    .in_car    (a_car_r),
    .out_valid (sq_v),
    .out_ready (dv_in_ready),
    .out_root  (sq_root),
    .out_car   (sq_car)
  );

  // Three lane divider by S = 2 * root.
  logic       dv_v, o_rdy;
  div_stage_t dv_st;

  rmq_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_v),
    .in_ready  (dv_in_ready),
    .in_root   (sq_root),
    .in_car    (sq_car),
    .out_valid (dv_v),
    .out_ready (o_rdy),
    .out_st    (dv_st)
  );

  // Output register: clamp, restore sign, and force zeros when degenerate.
  logic               out_valid_r, sat_r, degen_r;
  logic signed [15:0] qw_r, qx_r, qy_r, qz_r;
  logic [DATA_W-1:0]  qv [LANES];
  logic               sat_nxt;

  always_comb begin
    logic [Q_W-1:0] m;
    logic           s;
    sat_nxt = 1'b0;
    for (int j = 0; j < LANES; j++) begin
      s = dv_st.ovf[j] || (dv_st.q[j] > Q_W'(LIM));
      m = s ? Q_W'(LIM) : dv_st.q[j];
      sat_nxt = sat_nxt | s;
      qv[j] = dv_st.car.neg[j] ? DATA_W'(-{1'b0, m}) : DATA_W'({1'b0, m});
    end
  end

  assign o_rdy = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_rdy) begin
      out_valid_r <= dv_v;
    end
    if (o_rdy && dv_v) begin
      degen_r <= dv_st.car.degen;
      if (dv_st.car.degen) begin
        qw_r  <= '0;
        qx_r  <= '0;
        qy_r  <= '0;
        qz_r  <= '0;
        sat_r <= 1'b0;
      end else begin
        qw_r  <= dv_st.qw;
        qx_r  <= qv[0];
        qy_r  <= qv[1];
        qz_r  <= qv[2];
        sat_r <= sat_nxt;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_qw         = qw_r;
  assign out_qx         = qx_r;
  assign out_qy         = qy_r;
  assign out_qz         = qz_r;
  assign out_degenerate = degen_r;
  assign out_saturated  = sat_r;

  `RMQ_ASSERT(a_degen_zero, clk, rst_n, out_valid && out_degenerate |-> out_qw == 16'sd0 && out_qx == 16'sd0 && out_qy == 16'sd0 && out_qz == 16'sd0 && !out_saturated, "degenerate word carries nonzero data")
  `RMQ_ASSERT(a_qw_pos, clk, rst_n, out_valid && !out_degenerate |-> out_qw > 16'sd0, "scalar part not positive on a regular word")
  `RMQ_ASSERT(a_pipe_hold, clk, rst_n, sq_v && !dv_in_ready |=> sq_v && $stable(sq_root), "root stage lost a word under stall")
  `RMQ_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid after reset")
endmodule

@@ bench/testbench.sv @@
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rmq_pkg::*;

  typedef struct {
    logic signed [15:0] e [9];
  } matrix_t;

  typedef struct {
    logic signed [15:0] qw, qx, qy, qz;
    logic               degenerate, saturated;
  } quat_t;

  typedef struct {
    matrix_t m;
    bit      typed;
    quat_t   q;
  } row_t;

  localparam int TIMEOUT_CYCLES = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_r [9];
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_qw, out_qx, out_qy, out_qz;
  logic out_degenerate, out_saturated;

  quat_t quat_q[$];
  row_t  directed[$];
  int    cyc = 0;
  int    errors = 0;

  always #1 clk = ~clk;

  rotation_matrix_to_quaternion i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_r00(in_r[0]), .in_r01(in_r[1]), .in_r02(in_r[2]),
    .in_r10(in_r[3]), .in_r11(in_r[4]), .in_r12(in_r[5]),
    .in_r20(in_r[6]), .in_r21(in_r[7]), .in_r22(in_r[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_qw(out_qw), .out_qx(out_qx), .out_qy(out_qy), .out_qz(out_qz),
    .out_degenerate(out_degenerate), .out_saturated(out_saturated)
  );

  // Bitwise integer square root, floor.
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Signed difference over the doubled root, truncated and clamped.
  function automatic logic signed [15:0] div_clamp(longint d, longint unsigned den,
                                                   inout logic sat);
    longint unsigned mag, q;
    mag = (d < 0) ? -d : d;
    q = (mag << FRAC_BITS) / den;
    if (q > LIM) begin
      q = LIM;
      sat = 1'b1;
    end
    return 16'((d < 0) ? -longint'(q) : longint'(q));
  endfunction

  // Expected quaternion for one matrix, trace method.
  function automatic quat_t to_quat(matrix_t m);
    quat_t r;
    longint t;
    longint unsigned root, qw;
    logic sat;
    r = '{default: '0};
    t = longint'(m.e[0]) + longint'(m.e[4]) + longint'(m.e[8]) + ONE;
    if (t <= 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    root = int_sqrt(longint'(t) << FRAC_BITS);
    qw = root >> 1;
    if (qw > LIM) qw = LIM;
    r.qw = 16'(qw);
    sat = 1'b0;
    r.qx = div_clamp(longint'(m.e[7]) - m.e[5], root * 2, sat);
    r.qy = div_clamp(longint'(m.e[2]) - m.e[6], root * 2, sat);
    r.qz = div_clamp(longint'(m.e[3]) - m.e[1], root * 2, sat);
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic signed [15:0] to_q14(real v);
    int k;
    k = $rtoi(v * 16384.0 + ((v < 0) ? -0.5 : 0.5));
    if (k > 16384) k = 16384;
    if (k < -16384) k = -16384;
    return 16'(k);
  endfunction

  // Proper rotation built from a random quaternion.
  function automatic matrix_t random_rotation();
    matrix_t m;
    real w, x, y, z, n;
    w = $urandom_range(2000) - 1000.0;
    x = $urandom_range(2000) - 1000.0;
    y = $urandom_range(2000) - 1000.0;
    z = $urandom_range(2000) - 1000.0;
    n = $sqrt(w * w + x * x + y * y + z * z);
    if (n < 1.0) begin
      w = 1.0;
      n = 1.0;
    end
    w = w / n; x = x / n; y = y / n; z = z / n;
    m.e[0] = to_q14(1.0 - 2.0 * (y * y + z * z));
    m.e[1] = to_q14(2.0 * (x * y - w * z));
    m.e[2] = to_q14(2.0 * (x * z + w * y));
    m.e[3] = to_q14(2.0 * (x * y + w * z));
    m.e[4] = to_q14(1.0 - 2.0 * (x * x + z * z));
    m.e[5] = to_q14(2.0 * (y * z - w * x));
    m.e[6] = to_q14(2.0 * (x * z - w * y));
    m.e[7] = to_q14(2.0 * (y * z + w * x));
    m.e[8] = to_q14(1.0 - 2.0 * (x * x + y * y));
    return m;
  endfunction

  function automatic matrix_t fill(int d, int off);
    matrix_t m;
    for (int i = 0; i < 9; i++) m.e[i] = (i % 4 == 0) ? 16'(d) : 16'(off);
    return m;
  endfunction

  function automatic quat_t quat(int w, int deg);
    quat_t q;
    q = '{default: '0};
    q.qw = 16'(w);
    q.degenerate = 1'(deg);
    return q;
  endfunction

  function automatic bit quiet();
    return cyc >= 1500 && cyc < 2200;
  endfunction

  // Append one row to the directed table.
  task automatic add_row(matrix_t m, bit typed, quat_t q);
    row_t r;
    r.m = m;
    r.typed = typed;
    r.q = q;
    directed = {directed, r};
  endtask

  // Present one word and hold it until the block takes it.
  task automatic send(matrix_t m, quat_t q);
    while (!quiet() && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    for (int i = 0; i < 9; i++) in_r[i] <= m.e[i];
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    quat_q = {quat_q, q};
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > TIMEOUT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side stalls at random, except in the quiet window.
  always @(posedge clk) out_ready <= quiet() || ($urandom_range(99) >= 10);

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    quat_t e;
    if (rst_n && out_valid && out_ready) begin
      if (quat_q.size() == 0) begin
        $display("%0t: unexpected word qw=%0d qx=%0d qy=%0d qz=%0d", $time,
                 out_qw, out_qx, out_qy, out_qz);
        errors++;
      end else begin
        e = quat_q.pop_front();
        if (out_qw !== e.qw || out_qx !== e.qx || out_qy !== e.qy || out_qz !== e.qz ||
            out_degenerate !== e.degenerate || out_saturated !== e.saturated) begin
          $display("%0t: mismatch expected qw=%0d qx=%0d qy=%0d qz=%0d deg=%0b sat=%0b",
                   $time, e.qw, e.qx, e.qy, e.qz, e.degenerate, e.saturated);
          $display("%0t:          actual qw=%0d qx=%0d qy=%0d qz=%0d deg=%0b sat=%0b",
                   $time, out_qw, out_qx, out_qy, out_qz, out_degenerate, out_saturated);
          errors++;
        end
      end
    end
  end

  initial begin
    matrix_t m;
    int pick;
    for (int i = 0; i < 9; i++) in_r[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows: typed expectations where they are plain to read.
    add_row(fill(16384, 0), 1'b1, quat(16384, 0));
    add_row(fill(0, 0), 1'b1, quat(8192, 0));
    add_row(fill(-16384, 0), 1'b1, quat(0, 1));
    add_row(fill(-32768, -32768), 1'b1, quat(0, 1));
    add_row(fill(16384, -16384), 1'b1, quat(16384, 0));
    // Half turn about x: trace plus one is exactly zero.
    m = fill(-16384, 0);
    m.e[0] = 16384;
    add_row(m, 1'b1, quat(0, 1));
    add_row(fill(32767, 32767), 1'b0, quat(0, 0));
    add_row(fill(-5461, 0), 1'b0, quat(0, 0));
    m = fill(-5461, 0);
    m.e[7] = 16384; m.e[5] = -16384; m.e[2] = -16384; m.e[6] = 16384;
    m.e[3] = 32767; m.e[1] = -32768;
    add_row(m, 1'b0, quat(0, 0));
    m = fill(-5461, 0);
    m.e[7] = -32768; m.e[5] = 32767;
    add_row(m, 1'b0, quat(0, 0));
    m = fill(16384, 16384);
    m.e[1] = -16384; m.e[5] = -16384; m.e[6] = -16384;
    add_row(m, 1'b0, quat(0, 0));
    foreach (directed[i])
      send(directed[i].m, directed[i].typed ? directed[i].q : to_quat(directed[i].m));

    // Mostly true rotations, mixed at random with in-range noise and full 16-bit noise.
    for (int n = 0; n < 1900; n++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        m = random_rotation();
      end else if (pick < 85) begin
        for (int i = 0; i < 9; i++) m.e[i] = 16'($urandom_range(32768) - 16384);
      end else begin
        for (int i = 0; i < 9; i++) m.e[i] = 16'($urandom());
      end
      send(m, to_quat(m));
    end
    in_valid <= 1'b0;

    while (quat_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ rotation_matrix_to_quaternion.f @@
+incdir+src
src/rmq_pkg.sv
src/rmq_sqrt.sv
src/rmq_div.sv
src/rotation_matrix_to_quaternion.sv
bench/testbench.sv
